[src/at_ipd_payload_deframer_defines.svh]
// Assertion macros shared by the deframer checker.
`ifndef AT_IPD_PAYLOAD_DEFRAMER_DEFINES_SVH
`define AT_IPD_PAYLOAD_DEFRAMER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define ATIPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define ATIPD_ASSERT_NEXT(label, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

[src/atipd_pkg.sv]
// Types, constants and helper functions for the +IPD payload deframer.
package atipd_pkg;

	localparam int PAYLOAD_CAPACITY = 256;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_TEXT = 3'd0,
		PH_PLUS = 3'd1,
		PH_I    = 3'd2,
		PH_P    = 3'd3,
		PH_D    = 3'd4,
		PH_LEN  = 3'd5,
		PH_DATA = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TEXT    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_DONE    = 2'd2
	} kind_t;

	// Compact description of all results caused by one input item.
	typedef struct packed {
		logic       is_data;     // payload/complete burst, else text burst
		logic [2:0] count;       // number of results, 0..5
		logic [2:0] replay;      // prefix chars replayed before ch
		logic [7:0] ch;          // the input byte
		logic       has_payload; // data burst starts with a payload byte
		logic [7:0] pos;
		logic [8:0] plen;
	} burst_t;

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = CH_PLUS;
			2'd1: c = CH_I;
			2'd2: c = CH_P;
			default: c = CH_D;
		endcase
		return c;
	endfunction

	// Character expected in prefix phase p.
	function automatic logic [7:0] expect_char(input phase_t p);
		logic [7:0] c;
		case (p)
			PH_PLUS: c = CH_I;
			PH_I:    c = CH_P;
			PH_P:    c = CH_D;
			default: c = CH_COMMA;
		endcase
		return c;
	endfunction

endpackage

[src/atipd_parse.sv]
// Frame recognizer: parser state and the result burst of each accepted byte.
module atipd_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            in_byte,
	output atipd_pkg::burst_t     burst
);

	atipd_pkg::phase_t phase_q, phase_d;
	logic [15:0] declared_q, declared_d;
	logic [15:0] seen_q, seen_d;
	logic [15:0] seen_inc;
	logic [15:0] plen_full;
	logic [7:0]  digit;
	logic        has_payload;
	logic        done;

	assign seen_inc  = seen_q + 16'd1;
	assign digit     = in_byte - atipd_pkg::CH_ZERO;
	assign plen_full = (32'(declared_q) > 32'(atipd_pkg::PAYLOAD_CAPACITY)) ?
		16'(atipd_pkg::PAYLOAD_CAPACITY) : declared_q;
	assign has_payload = 32'(seen_q) < 32'(atipd_pkg::PAYLOAD_CAPACITY);
	assign done        = seen_inc >= declared_q;

	always_comb begin
		phase_d    = phase_q;
		declared_d = declared_q;
		seen_d     = seen_q;
		burst             = '0;
		burst.ch          = in_byte;
		burst.pos         = seen_q[7:0];
		burst.plen        = plen_full[8:0];
		case (phase_q)
			atipd_pkg::PH_TEXT: begin
				if (in_byte == atipd_pkg::CH_PLUS) begin
					phase_d = atipd_pkg::PH_PLUS;
				end else begin
					burst.count = 3'd1;
				end
			end
			atipd_pkg::PH_PLUS, atipd_pkg::PH_I, atipd_pkg::PH_P, atipd_pkg::PH_D: begin
				if (in_byte == atipd_pkg::expect_char(phase_q)) begin
					if (phase_q == atipd_pkg::PH_D) begin
						declared_d = '0;
						phase_d    = atipd_pkg::PH_LEN;
					end else begin
						phase_d = atipd_pkg::phase_t'(phase_q + 3'd1);
					end
				end else begin
					// replay the matched prefix, then the breaking byte
					burst.replay = phase_q;
					burst.count  = phase_q + 3'd1;
					phase_d      = atipd_pkg::PH_TEXT;
				end
			end
			atipd_pkg::PH_LEN: begin
				if (in_byte >= atipd_pkg::CH_ZERO && in_byte <= atipd_pkg::CH_NINE) begin
					declared_d = (declared_q << 3) + (declared_q << 1) + {8'd0, digit};
				end else if (in_byte == atipd_pkg::CH_COLON) begin
					seen_d  = '0;
					phase_d = atipd_pkg::PH_DATA;
				end else begin
					phase_d = atipd_pkg::PH_TEXT;
				end
			end
			atipd_pkg::PH_DATA: begin
				burst.is_data     = 1'b1;
				burst.has_payload = has_payload;
				burst.count       = {2'b00, has_payload} + {2'b00, done};
				seen_d            = seen_inc;
				if (done) begin
					phase_d = atipd_pkg::PH_TEXT;
				end
			end
			default: begin
				phase_d = atipd_pkg::PH_TEXT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= atipd_pkg::PH_TEXT;
			declared_q <= '0;
			seen_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			declared_q <= declared_d;
			seen_q     <= seen_d;
		end
	end

endmodule

[src/at_ipd_payload_deframer.sv]
// Top level of the +IPD payload deframer: burst register and result register.
//
// Input channel: in_valid / in_stall with incoming_byte, one modem byte per item.
// Output channel: out_valid / out_stall with kind, value, position,
// packet_length and last. An item is taken at an edge where valid is high and
// stall is low.
// Each input byte yields zero to five results; last marks the final result of
// a byte. Bytes outside a +IPD frame come out as text, payload bytes carry
// their index, and a packet-complete result ends each frame. A header that
// breaks in its length field is dropped, along with the breaking byte.
// Results go out through the burst register and then the result register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver does not stall. A byte that gives more results holds the burst
// register until its last result is loaded, since the result register takes
// at most one result per cycle; in_stall is high until then. Bytes that give
// no result (prefix, length digits) pass at one per cycle while in_stall is low.
// When the receiver stalls, the result register holds, the burst register
// fills, and in_stall rises; nothing is lost.
// Reset clears the parser to text phase and empties both registers.
module at_ipd_payload_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] incoming_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [7:0] position,
	output logic [8:0] packet_length,
	output logic       last
);

	atipd_pkg::burst_t burst_new;
	atipd_pkg::burst_t burst_s1;
	logic              burst_vld_s1;
	logic [2:0]        idx_q;
	logic              accept;
	logic              out_load;
	logic              res_last;
	atipd_pkg::kind_t  res_kind;
	logic [7:0]        res_value;
	logic [7:0]        res_pos;
	logic [8:0]        res_plen;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        value_q;
	logic [7:0]        position_q;
	logic [8:0]        packet_length_q;
	logic              last_q;

	assign out_load = burst_vld_s1 && (!out_valid_q || !out_stall);
	assign res_last = idx_q == (burst_s1.count - 3'd1);
	assign in_stall = burst_vld_s1 && !(out_load && res_last);
	assign accept   = in_valid && !in_stall;

	atipd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (incoming_byte),
		.burst   (burst_new)
	);

	// pick result idx_q of the pending burst
	always_comb begin
		res_kind  = atipd_pkg::KIND_TEXT;
		res_value = burst_s1.ch;
		res_pos   = '0;
		res_plen  = '0;
		if (!burst_s1.is_data) begin
			if (idx_q < burst_s1.replay) begin
				res_value = atipd_pkg::prefix_char(idx_q[1:0]);
			end
		end else if (burst_s1.has_payload && idx_q == 3'd0) begin
			res_kind = atipd_pkg::KIND_PAYLOAD;
			res_pos  = burst_s1.pos;
		end else begin
			res_kind  = atipd_pkg::KIND_DONE;
			res_value = '0;
			res_plen  = burst_s1.plen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_vld_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (accept && burst_new.count != 3'd0) begin
			burst_vld_s1 <= 1'b1;
			idx_q        <= '0;
		end else if (out_load) begin
			if (res_last) begin
				burst_vld_s1 <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && burst_new.count != 3'd0) begin
			burst_s1 <= burst_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= burst_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q          <= res_kind;
			value_q         <= res_value;
			position_q      <= res_pos;
			packet_length_q <= res_plen;
			last_q          <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign value         = value_q;
	assign position      = position_q;
	assign packet_length = packet_length_q;
	assign last          = last_q;

endmodule

[src/atipd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
`include "at_ipd_payload_deframer_defines.svh"

module atipd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] kind,
	input logic [7:0] value,
	input logic [7:0] position,
	input logic [8:0] packet_length,
	input logic       last
);

	`ATIPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({kind, value, position, packet_length, last}), "stalled result changed")
	`ATIPD_ASSERT(a_done_form, !(out_valid && kind == atipd_pkg::KIND_DONE) || (value == 8'd0 && position == 8'd0 && last && 32'(packet_length) <= atipd_pkg::PAYLOAD_CAPACITY), "malformed packet complete")
	`ATIPD_ASSERT(a_text_form, !(out_valid && kind == atipd_pkg::KIND_TEXT) || (position == 8'd0 && packet_length == 9'd0), "text result with payload fields")
	`ATIPD_ASSERT_NEXT(a_payload_then_done, out_valid && !out_stall && kind == atipd_pkg::KIND_PAYLOAD && !last, out_valid && kind == atipd_pkg::KIND_DONE, "payload not followed by complete")

endmodule

bind at_ipd_payload_deframer atipd_checker u_atipd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.value         (value),
	.position      (position),
	.packet_length (packet_length),
	.last          (last)
);
